### design/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg: shared types and constants of the RGB 3x3 convolution filter
// Pixel, window column, line store entry, partial sum and control types,
// sizes of the image counters and the configuration register indexes.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 3;
    localparam int KERNEL_SIZE = 3;
    localparam int PIX_MAX     = 255;

    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int COEF_W   = 16;
    localparam int KCOL_W   = KERNEL_SIZE * COEF_W;
    localparam int FULL_W   = 25;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = FULL_W - FRAC_W;
    localparam int PSUM_W   = PROD_W + 2;
    localparam int TOTAL_W  = PSUM_W + 2;
    localparam int INDEX_W  = 3;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 48;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef pixel_t [KERNEL_SIZE-1:0] column_t;

    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } entry_t;

    typedef struct packed {
        logic signed [PSUM_W-1:0] red;
        logic signed [PSUM_W-1:0] green;
        logic signed [PSUM_W-1:0] blue;
    } psum_t;

    typedef struct packed {
        logic advance;
        logic load;
    } pipe_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             last;
    } tag_t;

    typedef enum logic [INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_COL0  = 3'd2,
        CFG_KERNEL_COL1  = 3'd3,
        CFG_KERNEL_COL2  = 3'd4
    } cfg_reg_t;

endpackage

### design/rgbc_line_store.sv
// ----------------------------------------------------------------------------
// rgbc_line_store: two line buffers in one memory
// Each entry keeps the pixels of the two rows above at one column. A read at
// acceptance, a write-back one word later, and a bypass for a repeated column.
// ----------------------------------------------------------------------------
module rgbc_line_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rgbc_pkg::pipe_ctrl_t        ctrl,
    input  logic [rgbc_pkg::COL_W-1:0]  addr,
    input  rgbc_pkg::pixel_t            pix,
    output logic                        col_valid,
    output rgbc_pkg::column_t           col
);

    rgbc_pkg::entry_t              mem [rgbc_pkg::MAX_WIDTH];
    rgbc_pkg::entry_t              rd_reg;
    rgbc_pkg::entry_t              fwd_val_reg;
    logic                          fwd_reg;
    logic                          valid_reg;
    logic [rgbc_pkg::COL_W-1:0]    addr_reg;
    rgbc_pkg::pixel_t              pix_reg;
    rgbc_pkg::entry_t              held;
    rgbc_pkg::entry_t              wr;

    assign held     = fwd_reg ? fwd_val_reg : rd_reg;
    assign wr.older = held.newer;
    assign wr.newer = pix_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            if (valid_reg)
            begin
                mem[addr_reg] <= wr;
            end
            if (ctrl.load)
            begin
                rd_reg <= mem[addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            addr_reg    <= addr;
            pix_reg     <= pix;
            fwd_val_reg <= wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            valid_reg <= ctrl.load;
            fwd_reg   <= ctrl.load && valid_reg && (addr == addr_reg);
        end
    end

    assign col_valid = valid_reg;
    assign col[0]    = held.older;
    assign col[1]    = held.newer;
    assign col[2]    = pix_reg;

endmodule

### design/rgbc_cell.sv
// ----------------------------------------------------------------------------
// rgbc_cell: one column of the 3x3 window
// Holds three pixels, hands them to the next cell on a shift, weights them
// by its kernel column and sums the truncated products per channel.
// ----------------------------------------------------------------------------
module rgbc_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rgbc_pkg::pipe_ctrl_t         ctrl,
    input  rgbc_pkg::column_t            col_in,
    input  logic [rgbc_pkg::KCOL_W-1:0]  kernel,
    output rgbc_pkg::column_t            col_out,
    output rgbc_pkg::psum_t              psum
);

    rgbc_pkg::column_t                    col_reg;
    logic signed [rgbc_pkg::PROD_W-1:0]   red_prod_reg   [rgbc_pkg::KERNEL_SIZE];
    logic signed [rgbc_pkg::PROD_W-1:0]   green_prod_reg [rgbc_pkg::KERNEL_SIZE];
    logic signed [rgbc_pkg::PROD_W-1:0]   blue_prod_reg  [rgbc_pkg::KERNEL_SIZE];
    rgbc_pkg::psum_t                      psum_reg;

    // Q8.8 product, truncated toward zero
    function automatic logic signed [rgbc_pkg::PROD_W-1:0] scaled_product
    (
        input logic [7:0]                        p,
        input logic signed [rgbc_pkg::COEF_W-1:0] coef
    );
        logic signed [rgbc_pkg::FULL_W-1:0] p_ext;
        logic signed [rgbc_pkg::FULL_W-1:0] c_ext;
        logic signed [rgbc_pkg::FULL_W-1:0] prod;
        logic signed [rgbc_pkg::FULL_W-1:0] adj;
        p_ext = rgbc_pkg::FULL_W'($signed({1'b0, p}));
        c_ext = rgbc_pkg::FULL_W'(coef);
        prod  = p_ext * c_ext;
        adj   = prod + rgbc_pkg::FULL_W'(rgbc_pkg::PIX_MAX);
        return prod[rgbc_pkg::FULL_W-1] ? adj[rgbc_pkg::FULL_W-1:rgbc_pkg::FRAC_W]
                                        : prod[rgbc_pkg::FULL_W-1:rgbc_pkg::FRAC_W];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctrl.load)
        begin
            col_reg <= col_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            for (int b = 0; b < rgbc_pkg::KERNEL_SIZE; b++)
            begin
                red_prod_reg[b]   <= scaled_product(col_reg[b].red,
                                         $signed(kernel[b*rgbc_pkg::COEF_W +: rgbc_pkg::COEF_W]));
                green_prod_reg[b] <= scaled_product(col_reg[b].green,
                                         $signed(kernel[b*rgbc_pkg::COEF_W +: rgbc_pkg::COEF_W]));
                blue_prod_reg[b]  <= scaled_product(col_reg[b].blue,
                                         $signed(kernel[b*rgbc_pkg::COEF_W +: rgbc_pkg::COEF_W]));
            end
            psum_reg.red   <= rgbc_pkg::PSUM_W'(red_prod_reg[0])
                            + rgbc_pkg::PSUM_W'(red_prod_reg[1])
                            + rgbc_pkg::PSUM_W'(red_prod_reg[2]);
            psum_reg.green <= rgbc_pkg::PSUM_W'(green_prod_reg[0])
                            + rgbc_pkg::PSUM_W'(green_prod_reg[1])
                            + rgbc_pkg::PSUM_W'(green_prod_reg[2]);
            psum_reg.blue  <= rgbc_pkg::PSUM_W'(blue_prod_reg[0])
                            + rgbc_pkg::PSUM_W'(blue_prod_reg[1])
                            + rgbc_pkg::PSUM_W'(blue_prod_reg[2]);
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

### design/rgb_3x3_convolution.sv
// ----------------------------------------------------------------------------
// rgb_3x3_convolution: 3x3 convolution filter on a raster RGB pixel stream
// Path: line store read, window cell load, per-tap products, partial sums, output word.
// Throughput: one pixel per cycle while the skid stage is empty, set by the single
// line store read and write-back per pixel and the three window cells shifting once per pixel.
// Reset: counters, window and handshake state clear; line stores stay
// undefined until written; registers return to 640, 480, 0, 256, 0.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rgbc_pkg::IN_W-1:0]       s_tdata,   // red, green, blue
    input  logic                            s_tuser,   // frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rgbc_pkg::OUT_W-1:0]      m_tdata,   // center_x, center_y, red, green, blue, pad
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgbc_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [rgbc_pkg::KCOL_W-1:0]     cfg_data
);

    logic [rgbc_pkg::WIDTH_W-1:0]   width_reg;
    logic [rgbc_pkg::HEIGHT_W-1:0]  height_reg;
    logic [rgbc_pkg::KCOL_W-1:0]    kcol_reg [rgbc_pkg::KERNEL_SIZE];

    logic [rgbc_pkg::COL_W-1:0]     col_reg;
    logic [rgbc_pkg::COL_W-1:0]     col_next;
    logic [rgbc_pkg::ROW_W-1:0]     row_reg;
    logic [rgbc_pkg::ROW_W-1:0]     row_next;

    logic [rgbc_pkg::WIDTH_W-1:0]   w_eff;
    logic [rgbc_pkg::HEIGHT_W-1:0]  h_eff;
    logic [rgbc_pkg::COL_W-1:0]     c0;
    logic [rgbc_pkg::ROW_W-1:0]     r0;
    logic [rgbc_pkg::COL_W-1:0]     cur_col;
    logic [rgbc_pkg::HEIGHT_W-1:0]  r1;
    logic [rgbc_pkg::ROW_W-1:0]     cur_row;
    logic [rgbc_pkg::WIDTH_W-1:0]   col_inc;
    logic [rgbc_pkg::HEIGHT_W-1:0]  row_inc;
    logic                           emit;
    logic                           frame_end;

    logic                           en;
    logic                           accept;
    rgbc_pkg::pixel_t               in_pix;
    rgbc_pkg::pipe_ctrl_t           ls_ctrl;
    rgbc_pkg::pipe_ctrl_t           cell_ctrl;
    logic                           ls_valid;
    rgbc_pkg::column_t              col_chain [rgbc_pkg::KERNEL_SIZE+1];
    rgbc_pkg::psum_t                cell_psum [rgbc_pkg::KERNEL_SIZE];

    rgbc_pkg::tag_t                 t1_reg;
    rgbc_pkg::tag_t                 t2_reg;
    rgbc_pkg::tag_t                 t3_reg;
    rgbc_pkg::tag_t                 t4_reg;

    logic signed [rgbc_pkg::TOTAL_W-1:0] total_red;
    logic signed [rgbc_pkg::TOTAL_W-1:0] total_green;
    logic signed [rgbc_pkg::TOTAL_W-1:0] total_blue;
    logic [rgbc_pkg::OUT_W-1:0]     res_data;
    logic                           res_valid;

    logic                           m_tvalid_reg;
    logic [rgbc_pkg::OUT_W-1:0]     out_data_reg;
    logic                           out_last_reg;
    logic                           skid_valid_reg;
    logic [rgbc_pkg::OUT_W-1:0]     skid_data_reg;
    logic                           skid_last_reg;

    function automatic logic [7:0] clamp_pixel(input logic signed [rgbc_pkg::TOTAL_W-1:0] v);
        logic [7:0] res;
        if (v < 0)
        begin
            res = 8'd0;
        end
        else if (v > rgbc_pkg::TOTAL_W'(rgbc_pkg::PIX_MAX))
        begin
            res = 8'(rgbc_pkg::PIX_MAX);
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= rgbc_pkg::WIDTH_W'(640);
            height_reg  <= rgbc_pkg::HEIGHT_W'(480);
            kcol_reg[0] <= '0;
            kcol_reg[1] <= rgbc_pkg::KCOL_W'(256);
            kcol_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rgbc_pkg::CFG_IMAGE_WIDTH:  width_reg   <= cfg_data[rgbc_pkg::WIDTH_W-1:0];
                rgbc_pkg::CFG_IMAGE_HEIGHT: height_reg  <= cfg_data[rgbc_pkg::HEIGHT_W-1:0];
                rgbc_pkg::CFG_KERNEL_COL0:  kcol_reg[0] <= cfg_data;
                rgbc_pkg::CFG_KERNEL_COL1:  kcol_reg[1] <= cfg_data;
                rgbc_pkg::CFG_KERNEL_COL2:  kcol_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < rgbc_pkg::WIDTH_W'(rgbc_pkg::MIN_SIZE))
        begin
            w_eff = rgbc_pkg::WIDTH_W'(rgbc_pkg::MIN_SIZE);
        end
        else if (width_reg > rgbc_pkg::WIDTH_W'(rgbc_pkg::MAX_WIDTH))
        begin
            w_eff = rgbc_pkg::WIDTH_W'(rgbc_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg < rgbc_pkg::HEIGHT_W'(rgbc_pkg::MIN_SIZE))
        begin
            h_eff = rgbc_pkg::HEIGHT_W'(rgbc_pkg::MIN_SIZE);
        end
        else if (height_reg > rgbc_pkg::HEIGHT_W'(rgbc_pkg::MAX_HEIGHT))
        begin
            h_eff = rgbc_pkg::HEIGHT_W'(rgbc_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // position of the incoming pixel and of the next one
    always_comb
    begin
        c0 = s_tuser ? '0 : col_reg;
        r0 = s_tuser ? '0 : row_reg;
        if ({1'b0, c0} >= w_eff)
        begin
            cur_col = '0;
            r1      = {1'b0, r0} + rgbc_pkg::HEIGHT_W'(1);
        end
        else
        begin
            cur_col = c0;
            r1      = {1'b0, r0};
        end
        cur_row = (r1 >= h_eff) ? '0 : r1[rgbc_pkg::ROW_W-1:0];

        col_inc = {1'b0, cur_col} + rgbc_pkg::WIDTH_W'(1);
        row_inc = {1'b0, cur_row} + rgbc_pkg::HEIGHT_W'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[rgbc_pkg::ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[rgbc_pkg::COL_W-1:0];
            row_next = cur_row;
        end

        emit      = (cur_col >= rgbc_pkg::COL_W'(2)) && (cur_row >= rgbc_pkg::ROW_W'(2));
        frame_end = ({1'b0, cur_col} == w_eff - rgbc_pkg::WIDTH_W'(1))
                 && ({1'b0, cur_row} == h_eff - rgbc_pkg::HEIGHT_W'(1));
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    assign in_pix.red   = s_tdata[7:0];
    assign in_pix.green = s_tdata[15:8];
    assign in_pix.blue  = s_tdata[23:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // tags follow the data through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
        end
        else if (en)
        begin
            t1_reg.valid <= accept && emit;
            t1_reg.x     <= cur_col - rgbc_pkg::COL_W'(1);
            t1_reg.y     <= cur_row - rgbc_pkg::ROW_W'(1);
            t1_reg.last  <= frame_end;
            t2_reg       <= t1_reg;
            t3_reg       <= t2_reg;
            t4_reg       <= t3_reg;
        end
    end

    assign ls_ctrl.advance   = en;
    assign ls_ctrl.load      = accept;
    assign cell_ctrl.advance = en;
    assign cell_ctrl.load    = en && ls_valid;

    rgbc_line_store u_line_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ls_ctrl),
        .addr      (cur_col),
        .pix       (in_pix),
        .col_valid (ls_valid),
        .col       (col_chain[rgbc_pkg::KERNEL_SIZE])
    );

    for (genvar i = 0; i < rgbc_pkg::KERNEL_SIZE; i++)
    begin : g_cell
        rgbc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .col_in  (col_chain[i+1]),
            .kernel  (kcol_reg[i]),
            .col_out (col_chain[i]),
            .psum    (cell_psum[i])
        );
    end

    always_comb
    begin
        total_red   = rgbc_pkg::TOTAL_W'(cell_psum[0].red)
                    + rgbc_pkg::TOTAL_W'(cell_psum[1].red)
                    + rgbc_pkg::TOTAL_W'(cell_psum[2].red);
        total_green = rgbc_pkg::TOTAL_W'(cell_psum[0].green)
                    + rgbc_pkg::TOTAL_W'(cell_psum[1].green)
                    + rgbc_pkg::TOTAL_W'(cell_psum[2].green);
        total_blue  = rgbc_pkg::TOTAL_W'(cell_psum[0].blue)
                    + rgbc_pkg::TOTAL_W'(cell_psum[1].blue)
                    + rgbc_pkg::TOTAL_W'(cell_psum[2].blue);
        res_data    = {2'b00, clamp_pixel(total_blue), clamp_pixel(total_green),
                       clamp_pixel(total_red), t4_reg.y, t4_reg.x};
    end

    assign res_valid = en && t4_reg.valid;

    // output word and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!m_tvalid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                m_tvalid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                m_tvalid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!m_tvalid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
            else
            begin
                out_data_reg <= res_data;
                out_last_reg <= t4_reg.last;
            end
        end
        else if (res_valid)
        begin
            skid_data_reg <= res_data;
            skid_last_reg <= t4_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_skid_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid word held without an output word");

    a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(m_tvalid_reg && !m_tready))
        else $error("skid stage filled while the output was free");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata[9:0] != 10'd0) && (m_tdata[21:10] != 12'd0))
        else $error("border pixel emitted");

endmodule

### dv/rgb_3x3_convolution_tb.sv
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_tb: self-checking bench for the RGB 3x3 convolution
// Streams raster pixels through the filter under random gaps and stalls on
// both sides and reprograms the image size and kernel between drained phases.
// Every filtered word is checked against a scoreboard fed by a behavioural
// line store and window model. A short directed run covers the extremes.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_tb;

    localparam logic [rgbc_pkg::INDEX_W-1:0] CFG_FIRST_SPARE = 3'd5;
    localparam logic [rgbc_pkg::INDEX_W-1:0] CFG_LAST_SPARE  = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int RANDOM_ITEMS = 780;

    typedef enum int {COEF_ANY, COEF_MILD, COEF_EDGE} coef_style_t;

    typedef struct packed {
        rgbc_pkg::pixel_t px;
        logic             frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic [rgbc_pkg::COL_W-1:0] center_x;
        logic [rgbc_pkg::ROW_W-1:0] center_y;
        rgbc_pkg::pixel_t           value;
        logic                       frame_last;
    } filtered_t;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [rgbc_pkg::IN_W-1:0]    s_tdata   = '0;
    logic                         s_tuser   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [rgbc_pkg::OUT_W-1:0]   m_tdata;
    logic                         m_tlast;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [rgbc_pkg::INDEX_W-1:0] cfg_index = '0;
    logic [rgbc_pkg::KCOL_W-1:0]  cfg_data  = '0;

    rgb_3x3_convolution dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter state as seen by the scoreboard
    logic [rgbc_pkg::WIDTH_W-1:0]  width_reg  = 11'd640;
    logic [rgbc_pkg::HEIGHT_W-1:0] height_reg = 13'd480;
    logic [rgbc_pkg::KCOL_W-1:0]   kernel_reg [rgbc_pkg::KERNEL_SIZE] = '{48'd0, 48'd256, 48'd0};
    rgbc_pkg::pixel_t    row_above     [rgbc_pkg::MAX_WIDTH];
    rgbc_pkg::pixel_t    row_two_above [rgbc_pkg::MAX_WIDTH];
    rgbc_pkg::pixel_t    win [rgbc_pkg::KERNEL_SIZE][rgbc_pkg::KERNEL_SIZE];
    int unsigned         col_pos = 0;
    int unsigned         row_pos = 0;

    pixel_item_t pixel_pending [$];
    filtered_t   filtered_due [$];

    int          errors       = 0;
    int          quiet_cycles = 0;
    logic        pix_fired    = 1'b0;
    int          src_pause    = 0;
    int          sink_stall   = 0;
    bit          src_gaps_on  = 1'b1;
    bit          sink_gaps_on = 1'b1;
    int          hold_ask     = 0;
    int          hold_seen    = 0;
    int unsigned gen_width    = 640;
    bit          need_frame_start = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < rgbc_pkg::MAX_WIDTH; i++)
        begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
        end
        for (int a = 0; a < rgbc_pkg::KERNEL_SIZE; a++)
        begin
            for (int b = 0; b < rgbc_pkg::KERNEL_SIZE; b++)
            begin
                win[a][b] = '0;
            end
        end
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [7:0] clamp_byte(int v);
        if (v < 0)
            return 8'd0;
        if (v > rgbc_pkg::PIX_MAX)
            return 8'(rgbc_pkg::PIX_MAX);
        return 8'(v);
    endfunction

    function automatic rgbc_pkg::pixel_t filter_window();
        int               acc_r;
        int               acc_g;
        int               acc_b;
        int               k;
        rgbc_pkg::pixel_t res;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int a = 0; a < rgbc_pkg::KERNEL_SIZE; a++)
        begin
            for (int b = 0; b < rgbc_pkg::KERNEL_SIZE; b++)
            begin
                k = $signed(kernel_reg[a][rgbc_pkg::COEF_W*b +: rgbc_pkg::COEF_W]);
                acc_r += (int'(win[a][b].red) * k) / (1 << rgbc_pkg::FRAC_W);
                acc_g += (int'(win[a][b].green) * k) / (1 << rgbc_pkg::FRAC_W);
                acc_b += (int'(win[a][b].blue) * k) / (1 << rgbc_pkg::FRAC_W);
            end
        end
        res.red   = clamp_byte(acc_r);
        res.green = clamp_byte(acc_g);
        res.blue  = clamp_byte(acc_b);
        return res;
    endfunction

    task automatic apply_register(logic [rgbc_pkg::INDEX_W-1:0] idx,
                                  logic [rgbc_pkg::KCOL_W-1:0] data);
        case (idx)
            rgbc_pkg::CFG_IMAGE_WIDTH:  width_reg  = data[rgbc_pkg::WIDTH_W-1:0];
            rgbc_pkg::CFG_IMAGE_HEIGHT: height_reg = data[rgbc_pkg::HEIGHT_W-1:0];
            rgbc_pkg::CFG_KERNEL_COL0:  kernel_reg[0] = data;
            rgbc_pkg::CFG_KERNEL_COL1:  kernel_reg[1] = data;
            rgbc_pkg::CFG_KERNEL_COL2:  kernel_reg[2] = data;
            default: ;
        endcase
    endtask

    task automatic predict_pixel(rgbc_pkg::pixel_t px, logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        filtered_t   res;
        w = clamp_size(width_reg, rgbc_pkg::MIN_SIZE, rgbc_pkg::MAX_WIDTH);
        h = clamp_size(height_reg, rgbc_pkg::MIN_SIZE, rgbc_pkg::MAX_HEIGHT);
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        for (int a = 0; a < rgbc_pkg::KERNEL_SIZE - 1; a++)
        begin
            for (int b = 0; b < rgbc_pkg::KERNEL_SIZE; b++)
            begin
                win[a][b] = win[a+1][b];
            end
        end
        win[2][0] = row_two_above[c];
        win[2][1] = row_above[c];
        win[2][2] = px;
        row_two_above[c] = row_above[c];
        row_above[c]     = px;
        if (c >= 2 && r >= 2)
        begin
            res.center_x   = rgbc_pkg::COL_W'(c - 1);
            res.center_y   = rgbc_pkg::ROW_W'(r - 1);
            res.value      = filter_window();
            res.frame_last = (c == w - 1) && (r == h - 1);
            filtered_due.push_back(res);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    function automatic int pick_pause(bit on);
        int roll;
        if (!on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sample handshakes, predict, score and watch for a hang
    always @(posedge clk)
    begin : monitor
        filtered_t got;
        filtered_t want;
        if (rst_n)
        begin
            pix_fired <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                predict_pixel(rgbc_pkg::pixel_t'({s_tdata[7:0], s_tdata[15:8],
                                                  s_tdata[23:16]}), s_tuser);
            if (m_tvalid && m_tready)
            begin
                {got.value.blue, got.value.green, got.value.red, got.center_y, got.center_x} =
                    m_tdata[45:0];
                got.frame_last = m_tlast;
                if (filtered_due.size() == 0)
                begin
                    $error("unexpected filtered word at x=%0d y=%0d", got.center_x, got.center_y);
                    errors++;
                end
                else
                begin
                    want = filtered_due.pop_front();
                    check_field("center_x", want.center_x, got.center_x);
                    check_field("center_y", want.center_y, got.center_y);
                    check_field("filtered_red", want.value.red, got.value.red);
                    check_field("filtered_green", want.value.green, got.value.green);
                    check_field("filtered_blue", want.value.blue, got.value.blue);
                    check_field("frame_last", want.frame_last, got.frame_last);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("rgb_3x3_convolution_tb: errors");
                    $finish;
                end
            end
        end
    end

    // hold the current word until taken, then advance to the next one
    always @(negedge clk)
    begin : driver
        pixel_item_t nxt;
        if (rst_n && (!s_tvalid || pix_fired))
        begin
            if (src_pause != 0)
            begin
                s_tvalid <= 1'b0;
                src_pause--;
            end
            else if (pixel_pending.size() != 0)
            begin
                nxt = pixel_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {nxt.px.blue, nxt.px.green, nxt.px.red};
                s_tuser  <= nxt.frame_start;
                src_pause = pick_pause(src_gaps_on);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (sink_stall != 0)
            begin
                m_tready <= 1'b0;
                sink_stall--;
            end
            else if (hold_seen != hold_ask)
            begin
                hold_seen++;
                m_tready <= 1'b0;
                sink_stall = LONG_HOLD - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_stall = pick_pause(sink_gaps_on);
            end
        end
    end

    task automatic write_register(logic [rgbc_pkg::INDEX_W-1:0] idx,
                                  logic [rgbc_pkg::KCOL_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_image_width(int unsigned w);
        logic [rgbc_pkg::KCOL_W-1:0] data;
        data = ($urandom_range(0, 3) == 0) ? rgbc_pkg::KCOL_W'({$urandom, $urandom}) : '0;
        data[rgbc_pkg::WIDTH_W-1:0] = rgbc_pkg::WIDTH_W'(w);
        if (clamp_size(w, rgbc_pkg::MIN_SIZE, rgbc_pkg::MAX_WIDTH) > gen_width)
            need_frame_start = 1'b1;
        gen_width = clamp_size(w, rgbc_pkg::MIN_SIZE, rgbc_pkg::MAX_WIDTH);
        write_register(rgbc_pkg::CFG_IMAGE_WIDTH, data);
    endtask

    task automatic set_image_height(int unsigned h);
        logic [rgbc_pkg::KCOL_W-1:0] data;
        data = ($urandom_range(0, 3) == 0) ? rgbc_pkg::KCOL_W'({$urandom, $urandom}) : '0;
        data[rgbc_pkg::HEIGHT_W-1:0] = rgbc_pkg::HEIGHT_W'(h);
        write_register(rgbc_pkg::CFG_IMAGE_HEIGHT, data);
    endtask

    function automatic logic [rgbc_pkg::COEF_W-1:0] random_coef(coef_style_t style);
        case (style)
            COEF_ANY:  return rgbc_pkg::COEF_W'($urandom);
            COEF_MILD: return rgbc_pkg::COEF_W'($urandom_range(0, 96) - 48);
            default:
            begin
                case ($urandom_range(0, 6))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'hFFFF;
                    3:       return 16'h0001;
                    4:       return 16'h0100;
                    5:       return 16'hFF00;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic rgbc_pkg::pixel_t random_pixel();
        rgbc_pkg::pixel_t p;
        p = rgbc_pkg::pixel_t'($urandom);
        if ($urandom_range(0, 7) == 0)
            p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0)
            p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    task automatic queue_pixel(rgbc_pkg::pixel_t px, bit fs);
        pixel_item_t item;
        item.px          = px;
        item.frame_start = fs;
        pixel_pending.push_back(item);
    endtask

    // hold off until the stream is empty and the pipeline has settled
    task automatic wait_for_idle();
        @(posedge clk);
        while (pixel_pending.size() != 0 || s_tvalid || filtered_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic stream_pixels(int unsigned count);
        bit first_start;
        first_start = need_frame_start || ($urandom_range(0, 4) < 2);
        need_frame_start = 1'b0;
        for (int i = 0; i < count; i++)
            queue_pixel(random_pixel(), (i == 0 && first_start) || ($urandom_range(0, 199) == 0));
        wait_for_idle();
    endtask

    task automatic configure_phase();
        int          roll;
        int unsigned size;
        coef_style_t style;
        if ($urandom_range(0, 9) < 7)
        begin
            roll = $urandom_range(0, 19);
            size = (roll < 14) ? $urandom_range(3, 12) :
                   (roll < 17) ? $urandom_range(0, 2) : $urandom_range(13, 48);
            set_image_width(size);
        end
        if ($urandom_range(0, 9) < 7)
        begin
            roll = $urandom_range(0, 19);
            size = (roll < 14) ? $urandom_range(3, 8) :
                   (roll < 17) ? $urandom_range(0, 2) : $urandom_range(9, 20);
            set_image_height(size);
        end
        style = coef_style_t'($urandom_range(0, 2));
        if ($urandom_range(0, 4) < 3)
            write_register(rgbc_pkg::CFG_KERNEL_COL0,
                           {random_coef(style), random_coef(style), random_coef(style)});
        if ($urandom_range(0, 4) < 3)
            write_register(rgbc_pkg::CFG_KERNEL_COL1,
                           {random_coef(style), random_coef(style), random_coef(style)});
        if ($urandom_range(0, 4) < 3)
            write_register(rgbc_pkg::CFG_KERNEL_COL2,
                           {random_coef(style), random_coef(style), random_coef(style)});
        if ($urandom_range(0, 19) < 3)
            write_register(rgbc_pkg::INDEX_W'(CFG_FIRST_SPARE + $urandom_range(0, 2)),
                           rgbc_pkg::KCOL_W'({$urandom, $urandom}));
    endtask

    initial
    begin : stimulus
        rgbc_pkg::pixel_t corner_pixels [12];
        int unsigned      n_items;
        int unsigned      random_done;
        int unsigned      phase_no;
        corner_pixels = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                          24'h0000FF, 24'h808080, 24'h7F7F7F, 24'h010203,
                          24'hFEFDFC, 24'hFFFFFF, 24'h000000, 24'h55AA33};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // four-wide frame of the smallest height, extreme coefficients, spare index ignored
        set_image_width(4);
        set_image_height(1);
        write_register(rgbc_pkg::CFG_KERNEL_COL0, {16'h8000, 16'h7FFF, 16'h0001});
        write_register(rgbc_pkg::CFG_KERNEL_COL1, {16'hFFFF, 16'h0100, 16'h0080});
        write_register(rgbc_pkg::CFG_KERNEL_COL2, {16'h0000, 16'hFF00, 16'h7FFF});
        write_register(CFG_LAST_SPARE, {rgbc_pkg::KCOL_W{1'b1}});
        for (int i = 0; i < 12; i++)
            queue_pixel(corner_pixels[i], i == 0);
        wait_for_idle();

        // tallest frame; stop mid-row
        set_image_width(5);
        set_image_height(8191);
        write_register(CFG_FIRST_SPARE, '0);
        for (int i = 0; i < 8; i++)
            queue_pixel(random_pixel(), i == 0);
        wait_for_idle();

        // width below the current column: advance to the next row
        set_image_width(0);
        write_register(rgbc_pkg::CFG_KERNEL_COL0, {16'hFFC0, 16'h0000, 16'h0020});
        write_register(rgbc_pkg::CFG_KERNEL_COL1, {16'h0040, 16'h0080, 16'h0040});
        write_register(rgbc_pkg::CFG_KERNEL_COL2, {16'h0020, 16'h0000, 16'hFFC0});
        for (int i = 0; i < 6; i++)
            queue_pixel(random_pixel(), 1'b0);
        wait_for_idle();

        // height below the current row: wrap to row zero
        set_image_height(2);
        for (int i = 0; i < 3; i++)
            queue_pixel(random_pixel(), 1'b0);
        wait_for_idle();

        // widest frame, wrap past the last column
        set_image_width(2047);
        set_image_height(3);
        write_register(rgbc_pkg::CFG_KERNEL_COL0, {random_coef(COEF_MILD),
                                                   random_coef(COEF_MILD),
                                                   random_coef(COEF_MILD)});
        stream_pixels(rgbc_pkg::MAX_WIDTH + 16);

        random_done = 0;
        phase_no    = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            configure_phase();
            src_gaps_on  = $urandom_range(0, 3) != 0;
            sink_gaps_on = $urandom_range(0, 3) != 0;
            n_items = $urandom_range(60, 200);
            if (phase_no == 1)
            begin
                n_items = 200;
                hold_ask++;
            end
            stream_pixels(n_items);
            random_done += n_items;
            phase_no++;
        end

        wait_for_idle();
        repeat (16) @(posedge clk);
        if (filtered_due.size() != 0)
        begin
            $error("%0d filtered words never arrived", filtered_due.size());
            errors++;
        end
        if (errors == 0)
            $display("rgb_3x3_convolution_tb: clean");
        else
            $display("rgb_3x3_convolution_tb: errors");
        $finish;
    end

endmodule
